### rtl/msiir_pkg.sv
package msiir_pkg;

  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned FRAC_BITS    = 9;
  localparam int unsigned SAMPLE_BITS  = 10;

  localparam int unsigned CH_W        = $clog2(NUM_CHANNELS);
  localparam int unsigned CH_FIELD_W  = 3;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned COEFF_W     = 8;
  localparam int unsigned COEFF_SHIFT = 8;
  localparam int unsigned XPREV_W     = SAMPLE_BITS + GAIN_W;
  localparam int unsigned STATE_W     = 32;
  localparam int unsigned PROD_W      = STATE_W + COEFF_W;
  localparam int unsigned SUM_W       = STATE_W + 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(10);
  localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(245);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ENABLE  = 2'd0,
    CFG_INPUT_GAIN     = 2'd1,
    CFG_FEEDBACK_COEFF = 2'd2
  } cfg_index_e;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_READ   = 1'b1
  } func_e;

  // one channel entry of the state memory
  typedef struct packed {
    logic [XPREV_W-1:0] xprev;
    logic [STATE_W-1:0] state;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### rtl/msiir_ram.sv
module msiir_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/multichannel_scan_iir_lowpass_top.sv
// Round-robin scanner with a per-channel first-order low-pass filter. A sample
// transfer (func 0) carries one conversion for the channel the external mux
// selects; it is stored raw or filtered as y = x_prev + x + ((y*coeff) >> 8)
// with x = sample*gain, and the mux select then moves to the next channel. A
// read transfer (func 1) returns any channel's value (state >> FRAC_BITS when
// filtering), saturated at 1023. Every transfer yields one result. The block
// takes one transfer per clock unless out_stall_i backs up into in_stall_o.
// The state memory read is registered at the accepting edge; the filter
// arithmetic, write-back and result register follow in stage 1 once it advances.
// Back-to-back hits on the same channel are forwarded from the last write, and
// per-channel valid bits make all channels read as zero right after reset,
// with no clearing pass. The user must write configuration through the cfg
// port (ready is always high) while no transfer is in flight; it is not enforced.
module multichannel_scan_iir_lowpass_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [msiir_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [msiir_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 func_i,
  input  logic [msiir_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [msiir_pkg::CH_FIELD_W-1:0]     read_channel_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [msiir_pkg::SAMPLE_BITS-1:0]    read_value_o,
  output logic [msiir_pkg::CH_FIELD_W-1:0]     stored_channel_o,
  output logic [msiir_pkg::CH_FIELD_W-1:0]     mux_select_o
);

  localparam int unsigned CH_W    = msiir_pkg::CH_W;
  localparam int unsigned STATE_W = msiir_pkg::STATE_W;
  localparam int unsigned XPREV_W = msiir_pkg::XPREV_W;
  localparam int unsigned SMP_W   = msiir_pkg::SAMPLE_BITS;
  localparam int unsigned NCH     = msiir_pkg::NUM_CHANNELS;

  // configuration registers
  logic                              filter_en_q;
  logic [msiir_pkg::GAIN_W-1:0]      gain_q;
  logic [msiir_pkg::COEFF_W-1:0]     coeff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b0;
      gain_q      <= msiir_pkg::GAIN_RESET;
      coeff_q     <= msiir_pkg::COEFF_RESET;
    end else if (cfg_valid_i) begin
      case (msiir_pkg::cfg_index_e'(cfg_index_i))
        msiir_pkg::CFG_FILTER_ENABLE:  filter_en_q <= cfg_data_i[0];
        msiir_pkg::CFG_INPUT_GAIN:     gain_q      <= cfg_data_i[msiir_pkg::GAIN_W-1:0];
        msiir_pkg::CFG_FEEDBACK_COEFF: coeff_q     <= cfg_data_i[msiir_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline control
  logic s1_valid_q, out_valid_q;
  logic in_accept, s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // scan position, advanced as each sample transfer is taken
  logic [CH_W-1:0] cur_ch_q, cur_ch_d;
  logic            in_is_sample;

  assign in_is_sample = (msiir_pkg::func_e'(func_i) == msiir_pkg::FUNC_SAMPLE);

  always_comb begin
    cur_ch_d = cur_ch_q;
    if (in_accept && in_is_sample) begin
      cur_ch_d = (cur_ch_q == CH_W'(NCH - 1)) ? '0 : cur_ch_q + CH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_ch_q <= '0;
    end else begin
      cur_ch_q <= cur_ch_d;
    end
  end

  // stage 0: issue the memory read
  logic [CH_W-1:0] rd_addr;
  logic            rd_in_range;

  assign rd_addr     = in_is_sample ? cur_ch_q : read_channel_i[CH_W-1:0];
  assign rd_in_range = in_is_sample || (32'(read_channel_i) < 32'(NCH));

  // stage 1 item registers
  logic                                s1_sample_item_q;
  logic [SMP_W-1:0]                    s1_sample_q;
  logic [CH_W-1:0]                     s1_addr_q;
  logic [msiir_pkg::CH_FIELD_W-1:0]    s1_chan_q;
  logic [msiir_pkg::CH_FIELD_W-1:0]    s1_mux_q;
  logic                                s1_in_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_item_q <= in_is_sample;
      s1_sample_q      <= sample_i;
      s1_addr_q        <= rd_addr;
      s1_chan_q        <= in_is_sample ? msiir_pkg::CH_FIELD_W'(cur_ch_q) : read_channel_i;
      s1_mux_q         <= msiir_pkg::CH_FIELD_W'(cur_ch_d);
      s1_in_range_q    <= rd_in_range;
    end
  end

  // state memory: x_prev and filter state per channel
  localparam int unsigned  ENTRY_W_L = msiir_pkg::ENTRY_W;
  logic                    wr_en;
  msiir_pkg::entry_t       wr_entry;
  logic [ENTRY_W_L-1:0]    ram_rdata;

  msiir_ram #(
    .WIDTH (ENTRY_W_L),
    .DEPTH (NCH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_entry),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // entries written since reset, plus the last write for forwarding
  logic [NCH-1:0]     ch_valid_q;
  logic               fwd_valid_q;
  logic [CH_W-1:0]    fwd_addr_q;
  msiir_pkg::entry_t  fwd_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_valid_q  <= '0;
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      ch_valid_q[s1_addr_q] <= 1'b1;
      fwd_valid_q           <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q  <= s1_addr_q;
      fwd_entry_q <= wr_entry;
    end
  end

  // stage 1: read-modify-write
  msiir_pkg::entry_t                  cur_entry;
  logic [XPREV_W-1:0]                 x_scaled;
  logic [msiir_pkg::PROD_W-1:0]       fb_prod;
  logic [msiir_pkg::SUM_W-1:0]        y_sum;
  logic [STATE_W-1:0]                 y_sat;
  logic [STATE_W-1:0]                 new_state;
  logic [STATE_W-1:0]                 val_state;
  logic [STATE_W-1:0]                 val_shifted;
  logic [SMP_W-1:0]                   val_sat;
  logic [SMP_W-1:0]                   result_value;

  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr_q)) begin
      cur_entry = fwd_entry_q;
    end else if (ch_valid_q[s1_addr_q]) begin
      cur_entry = msiir_pkg::entry_t'(ram_rdata);
    end else begin
      cur_entry = '0;
    end
  end

  assign x_scaled = XPREV_W'(s1_sample_q) * XPREV_W'(gain_q);
  assign fb_prod  = msiir_pkg::PROD_W'(cur_entry.state) * msiir_pkg::PROD_W'(coeff_q);
  assign y_sum    = msiir_pkg::SUM_W'(cur_entry.xprev) + msiir_pkg::SUM_W'(x_scaled)
                  + msiir_pkg::SUM_W'(fb_prod[msiir_pkg::PROD_W-1:msiir_pkg::COEFF_SHIFT]);
  // filter state saturates at all ones
  assign y_sat    = (|y_sum[msiir_pkg::SUM_W-1:STATE_W]) ? '1 : y_sum[STATE_W-1:0];

  assign new_state = filter_en_q ? y_sat : STATE_W'(s1_sample_q);

  // raw mode leaves x_prev untouched
  assign wr_en          = s1_adv && s1_sample_item_q;
  assign wr_entry.state = new_state;
  assign wr_entry.xprev = filter_en_q ? x_scaled : cur_entry.xprev;

  // visible value: drop fraction bits when filtering, clamp to sample range
  assign val_state    = s1_sample_item_q ? new_state : cur_entry.state;
  assign val_shifted  = filter_en_q ? (val_state >> msiir_pkg::FRAC_BITS) : val_state;
  assign val_sat      = (|val_shifted[STATE_W-1:SMP_W]) ? '1 : val_shifted[SMP_W-1:0];
  assign result_value = s1_in_range_q ? val_sat : '0;

  // result register
  logic [SMP_W-1:0]                    out_value_q;
  logic [msiir_pkg::CH_FIELD_W-1:0]    out_chan_q;
  logic [msiir_pkg::CH_FIELD_W-1:0]    out_mux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s1_adv || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q <= result_value;
      out_chan_q  <= s1_chan_q;
      out_mux_q   <= s1_mux_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = out_value_q;
  assign stored_channel_o = out_chan_q;
  assign mux_select_o     = out_mux_q;

endmodule
